// File: rtl/asfc_pkg.sv
// ----------------------------------------------------------------------------
// asfc_pkg
// Types, mode codes and conversion functions for the sample format converter.
// ----------------------------------------------------------------------------
package asfc_pkg;

  typedef enum logic [1:0] {
    MODE_S16_TO_F32 = 2'd0,
    MODE_S16_TO_S24 = 2'd1,
    MODE_F32_TO_S16 = 2'd2,
    MODE_S24_TO_S16 = 2'd3
  } conv_mode_t;

  typedef struct packed {
    logic [31:0] sample_in;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        is_last_out;
  } out_item_t;

  // Signed 16-bit to IEEE single, value s / 32768.
  function automatic logic [31:0] s16_to_f32(input logic [15:0] s);
    logic [15:0] mag;
    logic [3:0]  p;
    logic [15:0] norm;
    logic [7:0]  expo;
    begin
      mag = s[15] ? (16'd0 - s) : s;
      p = 4'd0;
      for (int i = 0; i < 16; i++) begin
        if (mag[i]) p = 4'(i);
      end
      norm = mag << (4'd15 - p);
      expo = 8'd112 + {4'd0, p};
      if (s == 16'd0) s16_to_f32 = 32'd0;
      else if (mag[15]) s16_to_f32 = {s[15], 8'd127, 23'd0};
      else s16_to_f32 = {s[15], expo, norm[14:0], 8'd0};
    end
  endfunction

  // IEEE single x to signed 16-bit: round(x * 2^31) ties even, then floor / 65536.
  function automatic logic [15:0] f32_to_s16(input logic [31:0] raw);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] frac;
    logic [23:0] m;
    logic [4:0]  k;
    logic [55:0] ext;
    logic [31:0] mag;
    logic [23:0] rem;
    logic [23:0] half;
    logic        up;
    logic [32:0] biased;
    logic [15:0] hi;
    begin
      sgn  = raw[31];
      e    = raw[30:23];
      frac = raw[22:0];
      m    = (e == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      k    = 5'd0;
      ext  = 56'd0;
      rem  = 24'd0;
      half = 24'd0;
      up   = 1'b0;
      mag  = 32'd0;
      if (e >= 8'd119) begin
        // exponent 119..126 shift left 0..7
        mag = 32'({m, 7'd0} >> (5'd7 - 5'(e - 8'd119)));
      end else if (e >= 8'd94 || e == 8'd0) begin
        k    = (e == 8'd0) ? 5'd0 : 5'(8'd119 - e);
        if (e == 8'd0) begin
          // shift 118 is far beyond the range: zero magnitude
          mag = 32'd0;
        end else begin
          ext  = {m, 32'd0} >> k;
          mag  = 32'(ext[55:32]);
          rem  = ext[31:8];
          half = 24'h800000;
          up   = (rem > half) || (rem == half && mag[0]);
          mag  = mag + {31'd0, up};
        end
      end
      biased = {1'b0, mag} + 33'd65535;
      hi = sgn ? (16'd0 - biased[31:16]) : mag[31:16];
      if (e == 8'hff) f32_to_s16 = (frac != 23'd0) ? 16'd0 : (sgn ? 16'h8000 : 16'h7fff);
      else if (e >= 8'd127) f32_to_s16 = sgn ? 16'h8000 : 16'h7fff;
      else if (mag == 32'd0) f32_to_s16 = 16'd0;
      else f32_to_s16 = hi;
    end
  endfunction

endpackage

// File: rtl/asfc_core.sv
// ----------------------------------------------------------------------------
// asfc_core
// Combinational conversion of one registered sample by mode.
// ----------------------------------------------------------------------------
module asfc_core (
  input  asfc_pkg::conv_mode_t mode,
  input  asfc_pkg::in_item_t   item_in,
  output asfc_pkg::out_item_t  item_out
);
  import asfc_pkg::*;

  logic [31:0] res;

  always_comb begin
    unique case (mode)
      MODE_S16_TO_F32: res = s16_to_f32(item_in.sample_in[15:0]);
      MODE_S16_TO_S24: res = {8'd0, item_in.sample_in[15:0], 8'd0};
      MODE_F32_TO_S16: res = {16'd0, f32_to_s16(item_in.sample_in)};
      MODE_S24_TO_S16: res = {16'd0, item_in.sample_in[23:8]};
      default:         res = 32'd0;
    endcase
    item_out.sample_out  = res;
    item_out.is_last_out = item_in.is_last;
  end
endmodule

// File: rtl/audio_sample_format_converter.sv
// ----------------------------------------------------------------------------
// audio_sample_format_converter
// Converts one audio sample per transfer between PCM widths and between PCM and float.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_item_t (sample_in, is_last)
//  out_    | output    | out_valid / out_stall| out_item_t (sample_out, is_last_out)
//  cfg_    | input     | cfg_wr_en            | cfg_wr_data (conversion_mode)
//
// One sample per cycle when not stalled; input register, then result register.
// rst_n is synchronous and clears both valid flags and the mode to s16->float.
// A stall on out_ holds the result; the input register advances whenever the
// result register is free or being drained, so in_stall is out_stall while full.
// ----------------------------------------------------------------------------
module audio_sample_format_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  asfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output asfc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data
);
  import asfc_pkg::*;

  conv_mode_t mode_r;
  in_item_t   in_r;
  logic       in_vld_r;
  out_item_t  out_r;
  logic       out_vld_r;
  out_item_t  conv;
  logic       out_free;
  logic       in_free;

  assign out_free = !out_vld_r || !out_stall;
  assign in_free  = !in_vld_r || out_free;
  assign in_stall = !in_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  asfc_core u_core (.mode(mode_r), .item_in(in_r), .item_out(conv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_S16_TO_F32;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= conv_mode_t'(cfg_wr_data);
      if (in_free) in_vld_r <= in_valid;
      if (out_free) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) in_r <= in_data;
    if (out_free && in_vld_r) out_r <= conv;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(out_r))
    else $error("result changed under stall");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_free |=> out_vld_r)
    else $error("staged item lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> !in_stall)
    else $error("stall with empty result register");
endmodule
